FILE: hw/rtl/dpmw_pkg.sv
package dpmw_pkg;

   // Fixed field widths of the channels and the configuration register.
   localparam int VCOUNT_W = 7;
   localparam int CMD_W    = 2;
   localparam int VERTEX_W = 6;
   localparam int WEIGHT_W = 16;
   localparam int TOTAL_W  = 22;

   // Defaults for the top-level parameters.
   localparam int MAX_VERTICES_DEF = 64;
   localparam int WEIGHT_BITS_DEF  = 16;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_WRITE   = 2'd0;
   localparam cmd_type CMD_CLEAR   = 2'd1;
   localparam cmd_type CMD_COMPUTE = 2'd2;

   // Item handed from the port logic to the engine.
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      logic [WEIGHT_W-1:0] weight;
   } item_type;

   // Finished result offered by the engine.
   typedef struct packed {
      logic               valid;
      logic [TOTAL_W-1:0] total_weight;
      logic               connected;
   } result_type;

endpackage

FILE: hw/rtl/dpmw_ifs.sv
interface dpmw_req_if import dpmw_pkg::*; ();
   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [VERTEX_W-1:0] from_vertex;
   logic [VERTEX_W-1:0] to_vertex;
   logic [WEIGHT_W-1:0] weight;

   modport source (output valid, cmd, from_vertex, to_vertex, weight, input ready);
   modport sink (input valid, cmd, from_vertex, to_vertex, weight, output ready);
endinterface

interface dpmw_rsp_if import dpmw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] total_weight;
   logic               connected;

   modport source (output valid, total_weight, connected, input ready);
   modport sink (input valid, total_weight, connected, output ready);
endinterface

FILE: hw/rtl/dpmw_engine.sv
module dpmw_engine import dpmw_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  item_type            item,
   input  logic [VCOUNT_W-1:0] vcount,
   output logic                idle,
   output result_type          result,
   input  logic                result_take
);

   localparam int VW         = $clog2(MAX_VERTICES);
   localparam int NW         = VW + 1;
   localparam int EAW        = 2 * VW;
   localparam int EDGE_DEPTH = 1 << EAW;
   localparam int SUM_W      = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;

   localparam logic [WEIGHT_BITS-1:0] NO_EDGE   = '1;
   localparam logic [TOTAL_W-1:0]     TOTAL_MAX = '1;
   localparam logic [NW-1:0]          N_MAX     = NW'(MAX_VERTICES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_SWEEP,
      ST_DECIDE,
      ST_DONE
   } state_type;

   // Edge weights, row = first vertex, column = second vertex.
   logic [WEIGHT_BITS-1:0] edge_mem [EDGE_DEPTH];
   // Per-vertex node record: {in tree, best cost}.
   logic [WEIGHT_BITS:0]   node_mem [MAX_VERTICES];

   logic                   edge_we;
   logic [EAW-1:0]         edge_waddr;
   logic [WEIGHT_BITS-1:0] edge_wdata;
   logic [EAW-1:0]         edge_raddr_a;
   logic [EAW-1:0]         edge_raddr_b;
   logic [WEIGHT_BITS-1:0] edge_rd_a_ff;
   logic [WEIGHT_BITS-1:0] edge_rd_b_ff;

   logic                   node_we;
   logic [VW-1:0]          node_waddr;
   logic [WEIGHT_BITS:0]   node_wdata;
   logic [VW-1:0]          node_raddr;
   logic [WEIGHT_BITS:0]   node_rd_ff;

   state_type              state_ff, state_in;
   logic [EAW-1:0]         clr_addr_ff, clr_addr_in;
   logic [NW-1:0]          nv_ff, nv_in;
   logic [NW-1:0]          idx_ff, idx_in;
   logic                   s1_vld_ff, s1_vld_in;
   logic [VW-1:0]          s1_idx_ff, s1_idx_in;
   logic [VW-1:0]          pick_ff, pick_in;
   logic [VW-1:0]          pick_acc_ff, pick_acc_in;
   logic [WEIGHT_BITS-1:0] low_acc_ff, low_acc_in;
   logic [NW-1:0]          rounds_ff, rounds_in;
   logic [TOTAL_W-1:0]     sum_ff, sum_in;
   logic                   conn_ff, conn_in;

   logic [NW-1:0]          n_eff;
   logic [WEIGHT_BITS-1:0] w_item;
   logic                   item_in_range;
   logic [VW-1:0]          issue_idx;
   logic [WEIGHT_BITS-1:0] link;
   logic                   node_t;
   logic [WEIGHT_BITS-1:0] node_b;
   logic [WEIGHT_BITS-1:0] cand;
   logic                   eligible;
   logic [SUM_W-1:0]       sum_wide;
   logic [TOTAL_W-1:0]     sum_next;

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      edge_rd_a_ff <= edge_mem[edge_raddr_a];
      edge_rd_b_ff <= edge_mem[edge_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   always_comb begin
      if (vcount == '0) begin
         n_eff = NW'(1);
      end else if (32'(vcount) > 32'(MAX_VERTICES)) begin
         n_eff = N_MAX;
      end else begin
         n_eff = NW'(vcount);
      end
   end

   assign w_item        = WEIGHT_BITS'(item.weight);
   assign item_in_range = (32'(item.from_vertex) < 32'(MAX_VERTICES)) &&
                          (32'(item.to_vertex) < 32'(MAX_VERTICES));
   assign issue_idx     = idx_ff[VW-1:0];
   assign link          = (edge_rd_a_ff < edge_rd_b_ff) ? edge_rd_a_ff : edge_rd_b_ff;
   assign node_t        = node_rd_ff[WEIGHT_BITS];
   assign node_b        = node_rd_ff[WEIGHT_BITS-1:0];
   assign sum_wide      = SUM_W'(sum_ff) + SUM_W'(low_acc_ff);
   assign sum_next      = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_wide);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      nv_in        = nv_ff;
      idx_in       = idx_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = s1_idx_ff;
      pick_in      = pick_ff;
      pick_acc_in  = pick_acc_ff;
      low_acc_in   = low_acc_ff;
      rounds_in    = rounds_ff;
      sum_in       = sum_ff;
      conn_in      = conn_ff;

      edge_we      = 1'b0;
      edge_waddr   = {VW'(item.from_vertex), VW'(item.to_vertex)};
      edge_wdata   = w_item;
      edge_raddr_a = {issue_idx, pick_ff};
      edge_raddr_b = {pick_ff, issue_idx};
      node_we      = 1'b0;
      node_waddr   = s1_idx_ff;
      node_wdata   = {1'b0, link};
      node_raddr   = issue_idx;
      cand         = link;
      eligible     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            edge_we    = 1'b1;
            edge_waddr = clr_addr_ff;
            edge_wdata = NO_EDGE;
            clr_addr_in = clr_addr_ff + EAW'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (item.valid) begin
               case (item.cmd)
                  CMD_WRITE: begin
                     edge_we = item_in_range;
                  end
                  CMD_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_COMPUTE: begin
                     // Vertex 0 seeds the tree.
                     node_we     = 1'b1;
                     node_waddr  = '0;
                     node_wdata  = {1'b1, NO_EDGE};
                     nv_in       = n_eff;
                     idx_in      = NW'(1);
                     low_acc_in  = NO_EDGE;
                     pick_acc_in = '0;
                     pick_in     = '0;
                     rounds_in   = '0;
                     sum_in      = '0;
                     state_in    = ST_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INIT, ST_SWEEP: begin
            if (state_ff == ST_INIT) begin
               edge_raddr_a = {{VW{1'b0}}, issue_idx};
               edge_raddr_b = {issue_idx, {VW{1'b0}}};
            end

            if (idx_ff < nv_ff) begin
               s1_vld_in = 1'b1;
               s1_idx_in = issue_idx;
               idx_in    = idx_ff + NW'(1);
            end else if (!s1_vld_ff) begin
               state_in = ST_DECIDE;
            end

            // Second stage: read data is back, update the node record.
            if (s1_vld_ff) begin
               if (state_ff == ST_INIT) begin
                  node_we  = 1'b1;
                  eligible = 1'b1;
               end else if (s1_idx_ff == pick_ff) begin
                  node_we    = 1'b1;
                  node_wdata = {1'b1, node_b};
               end else if (!node_t) begin
                  cand       = (node_b < link) ? node_b : link;
                  node_we    = 1'b1;
                  node_wdata = {1'b0, cand};
                  eligible   = 1'b1;
               end
               if (eligible && (cand < low_acc_ff)) begin
                  low_acc_in  = cand;
                  pick_acc_in = s1_idx_ff;
               end
            end
         end

         ST_DECIDE: begin
            if (rounds_ff == nv_ff - NW'(1)) begin
               conn_in  = 1'b1;
               state_in = ST_DONE;
            end else if (low_acc_ff == NO_EDGE) begin
               sum_in   = '0;
               conn_in  = 1'b0;
               state_in = ST_DONE;
            end else begin
               sum_in    = sum_next;
               rounds_in = rounds_ff + NW'(1);
               pick_in   = pick_acc_ff;
               if (rounds_ff + NW'(1) == nv_ff - NW'(1)) begin
                  conn_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  idx_in     = '0;
                  low_acc_in = NO_EDGE;
                  state_in   = ST_SWEEP;
               end
            end
         end

         ST_DONE: begin
            if (result_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         s1_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         s1_vld_ff   <= s1_vld_in;
         s1_idx_ff   <= s1_idx_in;
         nv_ff       <= nv_in;
         idx_ff      <= idx_in;
         pick_ff     <= pick_in;
         pick_acc_ff <= pick_acc_in;
         low_acc_ff  <= low_acc_in;
         rounds_ff   <= rounds_in;
         sum_ff      <= sum_in;
         conn_ff     <= conn_in;
      end
   end

   assign idle                = (state_ff == ST_IDLE);
   assign result.valid        = (state_ff == ST_DONE);
   assign result.total_weight = sum_ff;
   assign result.connected    = conn_ff;

endmodule

FILE: hw/rtl/dense_prim_mst_weight_core.sv
// Channel    Dir  Handshake     Payload
// req_chan   in   valid/ready   cmd, from_vertex, to_vertex, weight
// rsp_chan   out  valid/ready   total_weight, connected
// csr        in   csr_we        csr_wdata (vertex_count)
//
// A clear item sweeps the edge memory through its single write port, all
// 4**clog2(MAX_VERTICES) entries (4096 by default); reset starts the same pass.
// A compute item over n active vertices runs a sweep for each tree round that reads one
// vertex's edge pair and node record per cycle.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken, and a new result holds in the engine until that register frees.
module dense_prim_mst_weight_core import dpmw_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   dpmw_req_if.sink            req_chan,
   dpmw_rsp_if.source          rsp_chan,
   input  logic                csr_we,
   input  logic [VCOUNT_W-1:0] csr_wdata
);

   // The vertex count register must only be written while the engine is idle; the block does not enforce this.
   logic [VCOUNT_W-1:0] vcount_ff, vcount_in;

   // Output register that decouples the engine from the result consumer.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_conn_ff, rsp_conn_in;

   item_type   item;
   result_type result;
   logic       eng_idle;
   logic       result_take;

   // The engine takes an item only when it has no work in progress.
   assign req_chan.ready   = eng_idle;
   assign item.valid       = req_chan.valid && eng_idle;
   assign item.cmd         = req_chan.cmd;
   assign item.from_vertex = req_chan.from_vertex;
   assign item.to_vertex   = req_chan.to_vertex;
   assign item.weight      = req_chan.weight;

   // A finished result moves on when the output register is empty or being drained.
   assign result_take = result.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      vcount_in    = csr_we ? csr_wdata : vcount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_total_in = rsp_total_ff;
      rsp_conn_in  = rsp_conn_ff;
      if (result_take) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = result.total_weight;
         rsp_conn_in  = result.connected;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_total_ff <= rsp_total_in;
      rsp_conn_ff  <= rsp_conn_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.total_weight = rsp_total_ff;
   assign rsp_chan.connected    = rsp_conn_ff;

   // The engine owns the edge and node memories and runs the tree rounds.
   dpmw_engine #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .vcount      (vcount_ff),
      .idle        (eng_idle),
      .result      (result),
      .result_take (result_take)
   );

endmodule

FILE: hw/rtl/dpmw_checker.sv
module dpmw_checker import dpmw_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input cmd_type            req_cmd,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [TOTAL_W-1:0] rsp_total_weight,
   input logic               rsp_connected
);

   // The edge memory clearing pass follows every reset.
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("item taken during the clearing pass after reset");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_CLEAR) |=> !req_ready)
      else $error("item taken right after a clear item");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_COMPUTE) |=> !req_ready)
      else $error("item taken right after a compute item");

   a_unconnected_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_connected) |-> (rsp_total_weight == '0))
      else $error("unconnected result with nonzero total");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result item dropped before it was taken");

endmodule

bind dense_prim_mst_weight_core dpmw_checker u_dpmw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_cmd          (req_chan.cmd),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_total_weight (rsp_chan.total_weight),
   .rsp_connected    (rsp_chan.connected)
);

FILE: test/mst_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the edge
// matrix and vertex count, and predicts every tree result that a compute item
// should return.
module mst_checker import dpmw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   dpmw_req_if                 req_mon,
   dpmw_rsp_if                 rsp_mon,
   input  logic                csr_we,
   input  logic [VCOUNT_W-1:0] csr_wdata,
   output int                  fail_count,
   output int                  awaiting
);

   localparam int                   VERTS     = MAX_VERTICES_DEF;
   localparam logic [WEIGHT_W-1:0]  NO_EDGE   = '1;
   localparam longint               TOTAL_MAX = (64'd1 << TOTAL_W) - 1;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic               linked;
   } tree_result_t;

   logic [WEIGHT_W-1:0] edge_wt [VERTS*VERTS];
   logic [VCOUNT_W-1:0] vcount;
   tree_result_t        tree_results_q [$];
   int                  misses = 0;

   assign fail_count = misses;

   // Undirected link cost: the cheaper of the two directed entries.
   function automatic logic [WEIGHT_W-1:0] link_wt(input int a, input int b);
      logic [WEIGHT_W-1:0] ab;
      logic [WEIGHT_W-1:0] ba;
      ab = edge_wt[a*VERTS + b];
      ba = edge_wt[b*VERTS + a];
      return (ab < ba) ? ab : ba;
   endfunction

   // Prim from vertex 0 over the active vertices.
   function automatic void grow_tree(input logic [VCOUNT_W-1:0] count,
                                     output tree_result_t res);
      int                  n;
      int                  pick;
      logic [WEIGHT_W-1:0] reach [VERTS];
      bit                  joined [VERTS];
      logic [WEIGHT_W-1:0] low;
      logic [WEIGHT_W-1:0] c;
      longint              sum;
      n = (count == 0) ? 1 : (count > VERTS) ? VERTS : int'(count);
      foreach (joined[i]) begin
         joined[i] = 1'b0;
         reach[i]  = NO_EDGE;
      end
      joined[0]  = 1'b1;
      res.total  = '0;
      res.linked = 1'b1;
      sum        = 0;
      for (int i = 1; i < n; i++) reach[i] = link_wt(0, i);
      for (int r = 1; r < n; r++) begin
         pick = 0;
         low  = NO_EDGE;
         for (int i = 0; i < n; i++) begin
            if (!joined[i] && reach[i] < low) begin
               low  = reach[i];
               pick = i;
            end
         end
         if (low == NO_EDGE) begin
            res.linked = 1'b0;
            return;
         end
         joined[pick] = 1'b1;
         sum = sum + low;
         if (sum > TOTAL_MAX) sum = TOTAL_MAX;
         for (int i = 0; i < n; i++) begin
            if (!joined[i]) begin
               c = link_wt(i, pick);
               if (c < reach[i]) reach[i] = c;
            end
         end
      end
      res.total = sum[TOTAL_W-1:0];
   endfunction

   always @(posedge clock) begin
      tree_result_t want;
      tree_result_t got;
      if (reset) begin
         foreach (edge_wt[i]) edge_wt[i] = NO_EDGE;
         vcount = VCOUNT_RESET;
         tree_results_q.delete();
         awaiting <= 0;
      end else begin
         if (csr_we) vcount = csr_wdata;

         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.total  = rsp_mon.total_weight;
            got.linked = rsp_mon.connected;
            if (tree_results_q.size() == 0) begin
               $display("%0t: unexpected result total_weight %0d connected %0b",
                        $time, got.total, got.linked);
               misses = misses + 1;
            end else begin
               want = tree_results_q.pop_front();
               if (got.total !== want.total) begin
                  $display("%0t: total_weight expected %0d got %0d",
                           $time, want.total, got.total);
                  misses = misses + 1;
               end
               if (got.linked !== want.linked) begin
                  $display("%0t: connected expected %0b got %0b",
                           $time, want.linked, got.linked);
                  misses = misses + 1;
               end
            end
         end

         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            case (req_mon.cmd)
               CMD_WRITE:
                  edge_wt[int'(req_mon.from_vertex)*VERTS + int'(req_mon.to_vertex)] =
                     req_mon.weight;
               CMD_CLEAR:
                  foreach (edge_wt[i]) edge_wt[i] = NO_EDGE;
               CMD_COMPUTE: begin
                  grow_tree(vcount, want);
                  tree_results_q = {tree_results_q, want};
               end
               default: ;
            endcase
         end

         awaiting <= tree_results_q.size();
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

// Top of the spanning tree engine bench. This module only makes stimulus and
// gives the verdict; all prediction and comparison lives in the checker.
module tb_top;
   import dpmw_pkg::*;

   // The block has no code for this command; it must be swallowed silently.
   localparam cmd_type CMD_UNUSED = 2'd3;

   // A clear sweeps 4096 entries, so this covers any result-free work still
   // in flight when the last expected result has come back.
   localparam int SETTLE_CYCLES = 4400;
   localparam int ITEM_GOAL     = 1800;
   localparam int PHASE_ITEMS   = 150;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we;
   logic [VCOUNT_W-1:0] csr_wdata;
   int                  fail_count;
   int                  awaiting;

   // Stimulus bookkeeping. The hurry flags switch off idling on one side for a
   // whole phase so that back-to-back traffic is seen as well.
   int                  items_sent = 0;
   bit                  req_hurry = 1'b0;
   bit                  rsp_hurry = 1'b0;

   dpmw_req_if req_chan ();
   dpmw_rsp_if rsp_chan ();

   dense_prim_mst_weight_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   mst_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs somewhere.
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side. For every item the receiver draws a stall, holds ready low
   // that long, then holds it high until a result is taken. Ready is only
   // assigned once per falling edge, so a zero stall keeps it high without a
   // glitch.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         stall = rsp_hurry ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Offers one item after a random gap and returns at the falling edge that
   // follows its acceptance. Valid is left high on return, so a following
   // call with no gap keeps the channel busy on every cycle.
   task automatic send_item(input cmd_type c, input logic [VERTEX_W-1:0] f,
                            input logic [VERTEX_W-1:0] t, input logic [WEIGHT_W-1:0] w);
      int gap;
      gap = req_hurry ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= c;
      req_chan.from_vertex <= f;
      req_chan.to_vertex   <= t;
      req_chan.weight      <= w;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      if (c != CMD_UNUSED) items_sent++;
   endtask

   task automatic send_write(input int f, input int t, input logic [WEIGHT_W-1:0] w);
      send_item(CMD_WRITE, f[VERTEX_W-1:0], t[VERTEX_W-1:0], w);
   endtask

   // Command items whose vertex and weight fields must not matter.
   task automatic send_bare(input cmd_type c);
      send_item(c, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)),
                WEIGHT_W'($urandom_range(0, 65535)));
   endtask

   // Stop offering items and wait until every predicted result is back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
   endtask

   // The register may only change with the engine idle, which includes any
   // clear sweep that produces no result of its own.
   task automatic set_vertex_count(input int v);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v[VCOUNT_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Weights for arbitrary edges: the absent code, the largest real weight,
   // zero and small values that produce ties show up often.
   function automatic logic [WEIGHT_W-1:0] any_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 16'hFFFE;
         3, 4:    return WEIGHT_W'($urandom_range(0, 15));
         default: return WEIGHT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Weights for tree links are always real edges.
   function automatic logic [WEIGHT_W-1:0] link_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 16'hFFFE;
         2, 3:    return WEIGHT_W'($urandom_range(0, 15));
         default: return WEIGHT_W'($urandom_range(0, 65534));
      endcase
   endfunction

   // One well-formed burst: an occasional clear, a random spanning tree over
   // the active vertices (with holes in some bursts), a few extra edges and
   // some noise, then a compute.
   task automatic grow_graph(input int n);
      int  u;
      int  extra;
      bit  broken;
      if ($urandom_range(0, 11) == 0) send_bare(CMD_CLEAR);
      broken = ($urandom_range(0, 3) == 0);
      for (int v = 1; v < n; v++) begin
         if (!broken || $urandom_range(0, 3) != 0) begin
            u = $urandom_range(0, v - 1);
            if ($urandom_range(0, 1) != 0) send_write(u, v, link_weight());
            else send_write(v, u, link_weight());
         end
      end
      extra = $urandom_range(0, n / 2 + 1);
      repeat (extra) begin
         case ($urandom_range(0, 5))
            0:       send_bare(CMD_UNUSED);
            1:       send_write($urandom_range(0, 63), $urandom_range(0, 63), any_weight());
            default: send_write($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                any_weight());
         endcase
      end
      send_bare(CMD_COMPUTE);
      // Now and then the sender holds back until the engine has answered.
      if ($urandom_range(0, 5) == 0) drain();
   endtask

   // One random phase at a fixed vertex count. Every fifth phase takes an
   // extreme count, including the out-of-range codes; large counts run only
   // two bursts since each sweep of a compute then covers many more vertices.
   task automatic random_phase(input int p);
      int vc;
      int n;
      int start;
      int bursts;
      if (p % 5 == 0) begin
         case ($urandom_range(0, 5))
            0:       vc = 0;
            1:       vc = 1;
            2:       vc = 64;
            3:       vc = 127;
            4:       vc = $urandom_range(65, 126);
            default: vc = $urandom_range(33, 63);
         endcase
      end else begin
         vc = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 32) : $urandom_range(2, 16);
      end
      set_vertex_count(vc);
      n = (vc == 0) ? 1 : (vc > 64) ? 64 : vc;
      req_hurry = ($urandom_range(0, 3) == 0);
      rsp_hurry = ($urandom_range(0, 3) == 0);
      start  = items_sent;
      bursts = 0;
      while (items_sent - start < PHASE_ITEMS && !(n > 24 && bursts >= 2)) begin
         grow_graph(n);
         bursts++;
      end
   endtask

   initial begin
      int p;
      req_chan.valid       = 1'b0;
      req_chan.cmd         = CMD_WRITE;
      req_chan.from_vertex = '0;
      req_chan.to_vertex   = '0;
      req_chan.weight      = '0;
      csr_we               = 1'b0;
      csr_wdata            = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. First a compute over the reset vertex count on the
      // freshly cleared matrix: nothing links, so the tree is unconnected.
      send_bare(CMD_COMPUTE);

      // Four vertices. The pair 0-1 uses zero in one direction and the
      // absent code in the other, 1-2 takes the smaller direction, vertex 3
      // only has a self loop, and 63-62 lies outside the active set.
      set_vertex_count(4);
      send_bare(CMD_COMPUTE);
      send_write(0, 1, 16'd0);
      send_write(1, 0, 16'hFFFF);
      send_write(2, 1, 16'hFFFE);
      send_write(1, 2, 16'd100);
      send_write(3, 3, 16'd5);
      send_write(63, 62, 16'd1);
      send_item(CMD_UNUSED, 6'd63, 6'd0, 16'hFFFF);
      send_bare(CMD_COMPUTE);
      // Reach vertex 3 from vertex 0, then add a cheaper path through 2 and
      // a tie between vertices 2 and 3.
      send_write(0, 3, 16'd9);
      send_write(3, 0, 16'd7);
      send_bare(CMD_COMPUTE);
      send_write(63, 63, 16'd0);
      send_write(0, 0, 16'hFFFF);
      send_write(2, 3, 16'd3);
      send_write(0, 2, 16'd7);
      send_bare(CMD_COMPUTE);

      // A single vertex gives an empty but connected tree; a count of zero
      // behaves the same, and any count above the array size is clamped.
      set_vertex_count(1);
      send_bare(CMD_COMPUTE);
      set_vertex_count(0);
      send_bare(CMD_COMPUTE);
      set_vertex_count(127);
      send_bare(CMD_COMPUTE);

      // Two vertices: clear, prove the clear, then the heaviest real edge.
      set_vertex_count(2);
      send_bare(CMD_CLEAR);
      send_bare(CMD_COMPUTE);
      send_write(1, 0, 16'hFFFE);
      send_bare(CMD_COMPUTE);

      // Random part.
      p = 0;
      while (items_sent < ITEM_GOAL) begin
         random_phase(p);
         p++;
      end

      // Everything is sent: wait for the last results, then give the engine
      // time to show any result that should not come.
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
